/* sv/rlfsd_pkg.sv */
// ----------------------------------------------------------------------------
// Run-length frame stream decoder package
// Shared widths, register indexes, event codes and the channel payload types.
// ----------------------------------------------------------------------------
package rlfsd_pkg;

  localparam int unsigned MaxCellsDefault = 4096;
  localparam int unsigned HeaderLen       = 14;
  localparam int unsigned RunLen          = 5;

  // Configuration register indexes.
  localparam logic [1:0] RegSourceSize = 2'd0;
  localparam logic [1:0] RegClipLevel  = 2'd1;
  localparam logic [1:0] RegLoopMask   = 2'd2;

  // Event codes reported with every result.
  localparam logic [2:0] EvConsumed  = 3'd0;
  localparam logic [2:0] EvFrame     = 3'd1;
  localparam logic [2:0] EvRestart   = 3'd2;
  localparam logic [2:0] EvFinished  = 3'd3;
  localparam logic [2:0] EvRejected  = 3'd4;
  localparam logic [2:0] EvTruncated = 3'd5;

  // Operation codes of an input beat.
  localparam logic OpStream = 1'b0;
  localparam logic OpRead   = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [7:0]  stream_byte;
    logic [11:0] cell_address;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [15:0] frame_index;
    logic [7:0]  cell_value;
    logic [15:0] movie_width;
    logic [15:0] movie_height;
    logic [7:0]  frame_rate;
    logic        playback_over;
  } out_item_t;

endpackage

/* sv/rlfsd_in_if.sv */
// ----------------------------------------------------------------------------
// Input channel interface
// Valid/ready channel that carries one input item per beat.
// ----------------------------------------------------------------------------
interface rlfsd_in_if
  import rlfsd_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* sv/rlfsd_out_if.sv */
// ----------------------------------------------------------------------------
// Output channel interface
// Valid/ready channel that carries one result item per beat.
// ----------------------------------------------------------------------------
interface rlfsd_out_if
  import rlfsd_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* sv/run_length_frame_stream_decoder_unit.sv */
// ----------------------------------------------------------------------------
// Run-length frame stream decoder
// Parses a DMV1 byte stream and paints run-length frames into a cell grid.
// ----------------------------------------------------------------------------
// One item is taken at a time. A header, name or count byte, and a run byte
// that does not close a run, passes through accept, parse and result. An
// in-range grid read passes through accept, the single-port cell memory read,
// a read wait and result. A byte that closes a valid run writes one cell per
// cycle through the memory's write port between parse and result. After the
// fourteenth header byte, the header check runs before its result is shown.
// Accepting the header and every loop restart sweep the whole memory, one cell
// per cycle; after reset a clearing pass runs before the first item is accepted.
// Configuration writes are taken at any time.
module run_length_frame_stream_decoder_unit
  import rlfsd_pkg::*;
#(
  parameter int unsigned MAX_CELLS = MaxCellsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  rlfsd_in_if.sink    in_ch,
  rlfsd_out_if.source out_ch
);

  localparam int unsigned AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int unsigned CW = $clog2(MAX_CELLS + 1);

  typedef enum logic [2:0] {
    PhHeader, PhName, PhCount, PhRuns, PhFinished, PhRejected, PhTruncated
  } phase_e;

  typedef enum logic [2:0] {
    StClear, StIdle, StWork, StFill, StRead, StReadWait, StOut
  } state_e;

  // Configuration registers.
  logic [31:0] source_size_q;
  logic [7:0]  clip_level_q, loop_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_size_q <= '1;
      clip_level_q  <= 8'd255;
      loop_mask_q   <= 8'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegSourceSize: source_size_q <= cfg_data_i;
        RegClipLevel:  clip_level_q  <= cfg_data_i[7:0];
        RegLoopMask:   loop_mask_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Cell memory: one port, written or read each cycle.
  logic [7:0]    mem [MAX_CELLS];
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata, mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata_q <= mem[mem_addr];
  end

  state_e      state_q;
  phase_e      phase_q;
  logic [31:0] offset_q, first_q;
  logic [7:0]  hdr_q [HeaderLen];
  logic [15:0] runs_left_q, frames_q;
  logic [7:0]  run_q [RunLen];
  logic [2:0]  rbc_q;
  logic [7:0]  byte_q;
  logic        op_q;
  logic [11:0] raddr_q;
  logic [CW-1:0] ptr_q, end_q;
  logic [7:0]  fill_val_q;
  logic        clr_then_work_q;
  logic [2:0]  ev_q;
  logic [7:0]  cv_q;

  // Header fields.
  logic [15:0] w, h, nlen, fcount;
  logic [31:0] cells;
  assign w      = {hdr_q[5], hdr_q[4]};
  assign h      = {hdr_q[7], hdr_q[6]};
  assign nlen   = {hdr_q[13], hdr_q[12]};
  assign fcount = {hdr_q[11], hdr_q[10]};
  assign cells  = w * h;

  // Run fields, with the closing byte taken from the held beat.
  logic [16:0] run_end;
  logic [7:0]  clipped;
  assign run_end = {1'b0, run_q[1], run_q[0]} + {1'b0, run_q[3], run_q[2]};
  assign clipped = (byte_q > clip_level_q) ? clip_level_q : byte_q;

  logic [15:0] count_val;
  logic [34:0] count_end;
  assign count_val = {byte_q, run_q[0]};
  assign count_end = {3'b0, offset_q} + 35'd1 + {19'b0, count_val} * 35'd5;

  logic hdr_ok;
  always_comb begin
    hdr_ok = (hdr_q[0] == "D") && (hdr_q[1] == "M") && (hdr_q[2] == "V") &&
             (hdr_q[3] == "1");
    if (source_size_q < 32'd14 ||
        ({16'b0, nlen} + 32'd14) > source_size_q ||
        (nlen > 16'd65521 && source_size_q < 32'd65536)) hdr_ok = 1'b0;
    if (w == 16'd0 || h == 16'd0 || hdr_q[8] == 8'd0) hdr_ok = 1'b0;
    if (cells > 32'(MAX_CELLS)) hdr_ok = 1'b0;
  end

  // The cycle after the fourteenth header byte is spent on the header check.
  logic hdr_chk;
  assign hdr_chk = (phase_q == PhHeader) && (offset_q == 32'd14) && !op_q;

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = ptr_q[AW-1:0];
    mem_wdata = fill_val_q;
    case (state_q)
      StClear, StFill: mem_we = 1'b1;
      StRead:          mem_addr = raddr_q[AW-1:0];
      default: ;
    endcase
  end

  assign in_ch.ready  = (state_q == StIdle);
  assign out_ch.valid = (state_q == StOut) && !hdr_chk;

  logic shown;
  assign shown = (phase_q != PhHeader) && (phase_q != PhRejected);
  always_comb begin
    out_ch.payload.event_res     = ev_q;
    out_ch.payload.frame_index   = frames_q;
    out_ch.payload.cell_value    = cv_q;
    out_ch.payload.movie_width   = shown ? w : 16'd0;
    out_ch.payload.movie_height  = shown ? h : 16'd0;
    out_ch.payload.frame_rate    = shown ? hdr_q[8] : 8'd0;
    out_ch.payload.playback_over = (phase_q == PhFinished) ||
                                   (phase_q == PhRejected) ||
                                   (phase_q == PhTruncated);
  end

  // Sequencer: holds the parse state, drives sweeps and registers results.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      phase_q <= PhHeader;
      offset_q <= '0;
      first_q <= '0;
      for (int i = 0; i < HeaderLen; i++) hdr_q[i] <= '0;
      for (int i = 0; i < RunLen; i++) run_q[i] <= '0;
      runs_left_q <= '0;
      frames_q <= '0;
      rbc_q <= '0;
      ptr_q <= '0;
      end_q <= CW'(MAX_CELLS);
      fill_val_q <= '0;
      clr_then_work_q <= 1'b0;
      ev_q <= EvConsumed;
      cv_q <= '0;
      byte_q <= '0;
      op_q <= OpStream;
      raddr_q <= '0;
    end else begin
      case (state_q)
        StClear, StFill: begin
          if (ptr_q + CW'(1) >= end_q) begin
            state_q <= clr_then_work_q ? StWork : (state_q == StClear && !op_q &&
                       phase_q == PhHeader && offset_q == 32'd0) ? StIdle : StOut;
            clr_then_work_q <= 1'b0;
          end
          ptr_q <= ptr_q + CW'(1);
        end
        StIdle: begin
          if (in_ch.valid) begin
            op_q    <= in_ch.payload.operation;
            byte_q  <= in_ch.payload.stream_byte;
            raddr_q <= in_ch.payload.cell_address;
            ev_q    <= EvConsumed;
            cv_q    <= '0;
            if (in_ch.payload.operation == OpRead) begin
              state_q <= (32'(in_ch.payload.cell_address) < 32'(MAX_CELLS)) ?
                         StRead : StOut;
            end else if (phase_q == PhCount && rbc_q == 3'd0 &&
                         frames_q >= fcount) begin
              // Loop restart: wipe the grid, then parse this byte.
              frames_q <= '0;
              offset_q <= first_q;
              ev_q <= EvRestart;
              ptr_q <= '0;
              end_q <= CW'(MAX_CELLS);
              fill_val_q <= '0;
              clr_then_work_q <= 1'b1;
              state_q <= StClear;
            end else begin
              state_q <= StWork;
            end
          end
        end
        StRead: state_q <= StReadWait;
        StReadWait: begin
          cv_q <= mem_rdata_q;
          state_q <= StOut;
        end
        StWork: begin
          state_q <= StOut;
          case (phase_q)
            PhHeader: begin
              hdr_q[offset_q[3:0]] <= byte_q;
              offset_q <= offset_q + 32'd1;
              if (offset_q == 32'd13) state_q <= StOut;
            end
            PhName: begin
              offset_q <= offset_q + 32'd1;
              runs_left_q <= runs_left_q - 16'd1;
              if (runs_left_q == 16'd1) begin
                rbc_q <= '0;
                if (fcount == 16'd0) begin
                  phase_q <= PhFinished;
                  ev_q <= EvFinished;
                end else begin
                  phase_q <= PhCount;
                end
              end
            end
            PhCount: begin
              offset_q <= offset_q + 32'd1;
              if (rbc_q == 3'd0) begin
                run_q[0] <= byte_q;
                rbc_q <= 3'd1;
              end else begin
                run_q[1] <= byte_q;
                rbc_q <= '0;
                if (count_end > {3'b0, source_size_q}) begin
                  phase_q <= PhTruncated;
                  ev_q <= EvTruncated;
                end else if (count_val == 16'd0) begin
                  frames_q <= frames_q + 16'd1;
                  if (frames_q + 16'd1 >= fcount && (hdr_q[9] & loop_mask_q) == 8'd0)
                  begin
                    phase_q <= PhFinished;
                    ev_q <= EvFinished;
                  end else begin
                    ev_q <= EvFrame;
                  end
                end else begin
                  runs_left_q <= count_val;
                  phase_q <= PhRuns;
                end
              end
            end
            PhRuns: begin
              offset_q <= offset_q + 32'd1;
              if (rbc_q == 3'd4) begin
                run_q[4] <= byte_q;
                rbc_q <= '0;
                runs_left_q <= runs_left_q - 16'd1;
                if (run_end <= 17'(cells) && run_end <= 17'(MAX_CELLS) &&
                    {run_q[3], run_q[2]} != 16'd0) begin
                  ptr_q <= CW'({run_q[1], run_q[0]});
                  end_q <= CW'(run_end);
                  fill_val_q <= clipped;
                  state_q <= StFill;
                end
                if (runs_left_q == 16'd1) begin
                  frames_q <= frames_q + 16'd1;
                  phase_q <= PhCount;
                  if (frames_q + 16'd1 >= fcount && (hdr_q[9] & loop_mask_q) == 8'd0)
                  begin
                    phase_q <= PhFinished;
                    ev_q <= EvFinished;
                  end else begin
                    ev_q <= EvFrame;
                  end
                end
              end else begin
                run_q[rbc_q] <= byte_q;
                rbc_q <= rbc_q + 3'd1;
              end
            end
            PhRejected: ev_q <= EvRejected;
            PhTruncated: ev_q <= EvTruncated;
            default: begin
              phase_q <= PhFinished;
              ev_q <= EvFinished;
            end
          endcase
        end
        StOut: begin
          // Header check happens once the fourteenth byte is stored.
          if (hdr_chk) begin
            if (!hdr_ok) begin
              phase_q <= PhRejected;
              ev_q <= EvRejected;
            end else begin
              first_q <= 32'd14 + {16'b0, nlen};
              frames_q <= '0;
              rbc_q <= '0;
              if (nlen != 16'd0) begin
                runs_left_q <= nlen;
                phase_q <= PhName;
              end else if (fcount == 16'd0) begin
                phase_q <= PhFinished;
                ev_q <= EvFinished;
              end else begin
                phase_q <= PhCount;
              end
              ptr_q <= '0;
              end_q <= CW'(MAX_CELLS);
              fill_val_q <= '0;
              state_q <= StClear;
            end
          end else if (out_ch.ready) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

/* sv/rlfsd_checker.sv */
// ----------------------------------------------------------------------------
// Run-length frame stream decoder checker
// Port-level checks of the decoder's channel behavior, bound to the top level.
// ----------------------------------------------------------------------------
module rlfsd_checker
  import rlfsd_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input out_item_t   out_payload
);

  // A result waiting to be taken stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("result changed while stalled");

  // The block never takes a new item while a result is still pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && out_valid))
    else $error("input accepted while result pending");

  // Once playback is over, it stays over.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_payload.playback_over |=>
      !out_valid || out_payload.playback_over)
    else $error("playback_over dropped");

  // The event code stays within its defined range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_payload.event_res <= EvTruncated)
    else $error("undefined event code");

endmodule

bind run_length_frame_stream_decoder_unit rlfsd_checker u_rlfsd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_payload(out_ch.payload)
);
